>>> sv/key_payload_minmax_selection_sort_assert.svh
// Assertion macros used by the sorter top module.
`ifndef KEY_PAYLOAD_MINMAX_SELECTION_SORT_ASSERT_SVH
`define KEY_PAYLOAD_MINMAX_SELECTION_SORT_ASSERT_SVH

// Same-cycle implication.
`define KPMSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KPMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/kpmss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kpmss_pkg;

  localparam int KEY_W            = 16;
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_WRB,
    ST_SW_WRA,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage
`default_nettype wire

>>> sv/key_payload_minmax_selection_sort.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one word per cycle, s_axis_tready high only in the load phase.
// Sort: each pass scans the span on the one compare unit, then moves the minimum
//   to the low end and the maximum to the high end by swaps through the
//   single-port-write store.
// Emit: each word enters the output register once it is free or being taken.
// Reset (synchronous, rst high) clears the sequencer, count and output valid.
`include "key_payload_minmax_selection_sort_assert.svh"
module key_payload_minmax_selection_sort #(
  parameter int MAX_ELEMENTS = kpmss_pkg::MAX_ELEMENTS_DEF,
  parameter int PAYLOAD_BITS = kpmss_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // key [15:0], payload_tag [16 +: PAYLOAD_BITS], zero fill above
  input  wire logic [((kpmss_pkg::KEY_W+PAYLOAD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tlast,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // sorted_key [15:0], sorted_payload [16 +: PAYLOAD_BITS], zero fill above
  output logic      [((kpmss_pkg::KEY_W+PAYLOAD_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tlast
);
  import kpmss_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int WORD_W = KEY_W + PAYLOAD_BITS;
  localparam int DATA_W = ((KEY_W + PAYLOAD_BITS + 7) / 8) * 8;

  state_t            state, state_next;
  logic [CNT_W-1:0]  load_count, load_count_next;
  logic [IDX_W-1:0]  lo, lo_next, hi, hi_next;
  logic [IDX_W-1:0]  j, j_next, k, k_next;
  logic [IDX_W-1:0]  last_idx, last_idx_next;
  logic [IDX_W-1:0]  pj, pj_next;
  logic              pv, pv_next;
  logic              second, second_next;
  logic [WORD_W-1:0] da, da_next, db, db_next;
  logic              out_valid, out_valid_next;
  logic [WORD_W-1:0] out_word, out_word_next;
  logic              out_last, out_last_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [IDX_W-1:0]  mn, mx, sa, sb, lo_inc, hi_dec;
  scan_ctl_t         scan_ctl;

  kpmss_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign scan_ctl.vld   = pv;
  assign scan_ctl.first = (pj == lo);

  kpmss_minmax #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_minmax (
    .clk(clk),
    .ctl(scan_ctl),
    .idx(pj),
    .key(ram_rdata[KEY_W-1:0]),
    .mn (mn),
    .mx (mx)
  );

  assign sa     = second ? ((mx == lo) ? mn : mx) : mn;
  assign sb     = second ? hi : lo;
  assign lo_inc = lo + IDX_W'(1);
  assign hi_dec = hi - IDX_W'(1);

  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_word);
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      pv         <= 1'b0;
      second     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      pv         <= pv_next;
      second     <= second_next;
      out_valid  <= out_valid_next;
    end
    lo       <= lo_next;
    hi       <= hi_next;
    j        <= j_next;
    k        <= k_next;
    last_idx <= last_idx_next;
    pj       <= pj_next;
    da       <= da_next;
    db       <= db_next;
    out_word <= out_word_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    lo_next         = lo;
    hi_next         = hi;
    j_next          = j;
    k_next          = k;
    last_idx_next   = last_idx;
    pj_next         = pj;
    pv_next         = 1'b0;
    second_next     = second;
    da_next         = da;
    db_next         = db;
    out_word_next   = out_word;
    out_last_next   = out_last;
    out_valid_next  = (out_valid && m_axis_tready) ? 1'b0 : out_valid;
    ram_we          = 1'b0;
    ram_waddr       = load_count[IDX_W-1:0];
    ram_wdata       = {s_axis_tdata[KEY_W +: PAYLOAD_BITS], s_axis_tdata[KEY_W-1:0]};
    ram_raddr       = j;

    unique case (state)
      ST_LOAD: begin
        if (s_axis_tvalid) begin
          ram_we = 1'b1;
          if (s_axis_tlast || load_count == CNT_W'(MAX_ELEMENTS - 1)) begin
            lo_next       = '0;
            hi_next       = load_count[IDX_W-1:0];
            last_idx_next = load_count[IDX_W-1:0];
            j_next        = '0;
            k_next        = '0;
            second_next   = 1'b0;
            state_next    = (load_count == '0) ? ST_EMIT_RD : ST_SCAN;
          end else begin
            load_count_next = load_count + CNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = j;
        pv_next   = 1'b1;
        pj_next   = j;
        j_next    = j + IDX_W'(1);
        if (j == hi) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_SW_RDA;
      end
      ST_SW_RDA: begin
        ram_raddr  = sa;
        state_next = ST_SW_RDB;
      end
      ST_SW_RDB: begin
        ram_raddr  = sb;
        da_next    = ram_rdata;
        state_next = ST_SW_WRB;
      end
      ST_SW_WRB: begin
        db_next    = ram_rdata;
        ram_we     = 1'b1;
        ram_waddr  = sb;
        ram_wdata  = da;
        state_next = ST_SW_WRA;
      end
      ST_SW_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = sa;
        ram_wdata = db;
        if (!second) begin
          second_next = 1'b1;
          state_next  = ST_SW_RDA;
        end else begin
          second_next = 1'b0;
          lo_next     = lo_inc;
          hi_next     = hi_dec;
          j_next      = lo_inc;
          state_next  = (lo_inc < hi_dec) ? ST_SCAN : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        ram_raddr = k;
        if (!out_valid || m_axis_tready) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_word_next  = ram_rdata;
        out_last_next  = (k == last_idx);
        out_valid_next = 1'b1;
        if (k == last_idx) begin
          load_count_next = '0;
          state_next      = ST_LOAD;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  `KPMSS_ASSERT_NOW(a_span_open, clk, rst, state == ST_SCAN, lo < hi && j <= hi, "scan outside span")
  `KPMSS_ASSERT_NOW(a_emit_free, clk, rst, state == ST_EMIT_LD, !out_valid, "output register busy")
  `KPMSS_ASSERT_NEXT(a_emit_load, clk, rst, state == ST_EMIT_LD, out_valid, "word not presented")
  `KPMSS_ASSERT_NEXT(a_set_done, clk, rst, state == ST_EMIT_LD && k == last_idx, state == ST_LOAD && load_count == '0 && out_last, "set not closed")

endmodule
`default_nettype wire

>>> sv/kpmss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module kpmss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/kpmss_minmax.sv
`timescale 1ns / 1ps
`default_nettype none
module kpmss_minmax #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                            clk,
  input  wire kpmss_pkg::scan_ctl_t            ctl,
  input  wire logic [$clog2(MAX_ELEMENTS)-1:0] idx,
  input  wire logic [kpmss_pkg::KEY_W-1:0]     key,
  output logic      [$clog2(MAX_ELEMENTS)-1:0] mn,
  output logic      [$clog2(MAX_ELEMENTS)-1:0] mx
);
  import kpmss_pkg::*;

  logic [KEY_W-1:0] min_key;
  logic [KEY_W-1:0] max_key;

  // first strict minimum and first strict maximum of the span
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (ctl.first) begin
        mn      <= idx;
        mx      <= idx;
        min_key <= key;
        max_key <= key;
      end else begin
        if (key < min_key) begin
          mn      <= idx;
          min_key <= key;
        end
        if (key > max_key) begin
          mx      <= idx;
          max_key <= key;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> verif/kpmss_sort_checker.sv
`timescale 1ns / 1ps
module kpmss_sort_checker #(
  parameter int MAX_SET = 64,
  parameter int TAG_W   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  input  wire logic s_tready,
  // key [15:0], payload_tag [16 +: TAG_W]
  input  wire logic [((kpmss_pkg::KEY_W+TAG_W+7)/8)*8-1:0] s_tdata,
  input  wire logic s_tlast,
  input  wire logic m_tvalid,
  input  wire logic m_tready,
  // sorted_key [15:0], sorted_payload [16 +: TAG_W]
  input  wire logic [((kpmss_pkg::KEY_W+TAG_W+7)/8)*8-1:0] m_tdata,
  input  wire logic m_tlast,
  output int        fails,
  output int        pending
);

  localparam int KW = kpmss_pkg::KEY_W;

  typedef struct packed {
    logic [KW-1:0]    key;
    logic [TAG_W-1:0] tag;
  } pair_t;

  typedef struct packed {
    logic [KW-1:0]    key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } sorted_word_t;

  pair_t        set_buf [MAX_SET];
  int unsigned  set_len = 0;
  sorted_word_t sorted_words_q [$];
  int           mismatches = 0;
  int           waiting = 0;

  assign fails   = mismatches;
  assign pending = waiting;

  function automatic void exchange_slots(int unsigned a, int unsigned b);
    pair_t t;
    t          = set_buf[a];
    set_buf[a] = set_buf[b];
    set_buf[b] = t;
  endfunction

  function automatic void minmax_sort_set(int unsigned n);
    int unsigned lo, hi, mn, mx;
    if (n < 2) return;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mn = lo;
      mx = lo;
      for (int unsigned j = lo + 1; j <= hi; j++) begin
        if (set_buf[j].key < set_buf[mn].key) mn = j;
        if (set_buf[j].key > set_buf[mx].key) mx = j;
      end
      exchange_slots(mn, lo);
      if (mx == lo) exchange_slots(mn, hi);
      else exchange_slots(mx, hi);
      lo++;
      hi--;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 100)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    sorted_word_t want;
    if (rst) begin
      set_len = 0;
      sorted_words_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        set_buf[set_len] = '{key: s_tdata[KW-1:0], tag: s_tdata[KW +: TAG_W]};
        set_len++;
        if (s_tlast || set_len == MAX_SET) begin
          minmax_sort_set(set_len);
          for (int unsigned k = 0; k < set_len; k++)
            sorted_words_q.push_back('{key: set_buf[k].key, tag: set_buf[k].tag,
                                       last: (k + 1 == set_len)});
          set_len = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (sorted_words_q.size() == 0) begin
          report_mismatch("word with nothing pending", m_tdata, 0);
        end else begin
          want = sorted_words_q.pop_front();
          if (m_tdata[KW-1:0] !== want.key)
            report_mismatch("sorted_key", m_tdata[KW-1:0], want.key);
          if (m_tdata[KW +: TAG_W] !== want.tag)
            report_mismatch("sorted_payload", m_tdata[KW +: TAG_W], want.tag);
          if (m_tlast !== want.last)
            report_mismatch("last_out", m_tlast, want.last);
        end
      end
    end
    waiting <= sorted_words_q.size();
  end

endmodule

>>> verif/tb_key_payload_minmax_selection_sort.sv
`timescale 1ns / 1ps
module tb_key_payload_minmax_selection_sort;

  localparam int KW             = kpmss_pkg::KEY_W;
  localparam int TAG_W          = 32;
  localparam int MAX_SET        = 64;
  localparam int DATA_W         = ((KW + TAG_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int RANDOM_ITEMS   = 330;
  localparam int FULL_OPEN_SET  = 3;
  localparam int FULL_LAST_SET  = 11;
  localparam int HOLD_CYCLES    = 700;

  typedef enum {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EXTREME, KEYS_FLAT} key_pattern_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  int fails;
  int pending;
  int cycle_count = 0;
  int rx_words = 0;
  int rx_wait = 0;
  bit rx_calm = 1'b0;
  bit rx_hold = 1'b0;

  key_payload_minmax_selection_sort #(
    .MAX_ELEMENTS(MAX_SET),
    .PAYLOAD_BITS(TAG_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  kpmss_sort_checker #(
    .MAX_SET(MAX_SET),
    .TAG_W(TAG_W)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata),
    .s_tlast(s_axis_tlast),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata),
    .m_tlast(m_axis_tlast),
    .fails(fails),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin : rx_side
    int gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      rx_words <= rx_words + 1;
      if (rx_words % 32 == 31) rx_calm <= ($urandom_range(0, 2) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 14);
      if (gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait       <= gap - 1;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // hold off the output long enough for the input side to back up
  initial begin
    wait (rx_words >= 120);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_word(logic [KW-1:0] key, logic [TAG_W-1:0] tag, logic last, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, key};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    int           sent;
    int           set_idx;
    int           n;
    key_pattern_t pattern;
    logic [15:0]  base;
    logic [15:0]  k;
    bit           calm;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single words, pairs, duplicates, max at span start, flat and sorted sets
    push_word(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_word(16'h0000, 32'h0000_0000, 1'b1, 1'b0);
    push_word(16'hFFFF, 32'h0000_0001, 1'b0, 1'b0);
    push_word(16'h0000, 32'h0000_0002, 1'b1, 1'b0);
    push_word(16'h0005, 32'h0000_000A, 1'b0, 1'b1);
    push_word(16'h0005, 32'h0000_000B, 1'b1, 1'b1);
    push_word(16'h0009, 32'hA000_0001, 1'b0, 1'b0);
    push_word(16'h0003, 32'hA000_0002, 1'b0, 1'b0);
    push_word(16'h0009, 32'hA000_0003, 1'b0, 1'b0);
    push_word(16'h0001, 32'hA000_0004, 1'b0, 1'b0);
    push_word(16'h0003, 32'hA000_0005, 1'b0, 1'b0);
    push_word(16'h0001, 32'hA000_0006, 1'b1, 1'b0);
    push_word(16'h1234, 32'h5555_5555, 1'b0, 1'b1);
    push_word(16'h1234, 32'hAAAA_AAAA, 1'b0, 1'b1);
    push_word(16'h1234, 32'h0F0F_0F0F, 1'b0, 1'b1);
    push_word(16'h1234, 32'hF0F0_F0F0, 1'b0, 1'b1);
    push_word(16'h1234, 32'h0000_0000, 1'b1, 1'b1);
    push_word(16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_word(16'h0001, 32'h0000_0000, 1'b0, 1'b0);
    push_word(16'hFFFE, 32'h8000_0000, 1'b0, 1'b0);
    push_word(16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);

    // drain everything before the random part
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_idx == FULL_OPEN_SET || set_idx == FULL_LAST_SET) n = MAX_SET;
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(13, MAX_SET - 1);
      else n = $urandom_range(1, 12);
      pattern = key_pattern_t'($urandom_range(0, 3));
      base    = 16'($urandom);
      calm    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        case (pattern)
          KEYS_WIDE: begin
            k = 16'($urandom);
          end
          KEYS_CLUSTERED: begin
            k = base + 16'($urandom_range(0, 3));
          end
          KEYS_EXTREME: begin
            k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
          default: begin
            k = base;
          end
        endcase
        push_word(k, $urandom, (i == n - 1) && (set_idx != FULL_OPEN_SET), calm);
      end
      sent += n;
      set_idx++;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
